/* sv/mesh_normal_tangent_gen_assert.svh */
// Assertion macros for the mesh normal/tangent generator.
// Used by the modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef MESH_NORMAL_TANGENT_GEN_ASSERT_SVH
`define MESH_NORMAL_TANGENT_GEN_ASSERT_SVH
`ifndef SYNTHESIS
`define MNTG_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mntg assertion failed");
`define MNTG_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mntg assertion failed");
`else
`define MNTG_ASSERT_IMP(label, ante, cons)
`define MNTG_ASSERT_NXT(label, ante, cons)
`endif
`endif

/* sv/mntg_pkg.sv */
// Package for the mesh normal/tangent generator: request and result types,
// operation codes, sequencer states and fixed-point helper functions.
package mntg_pkg;

  localparam int unsigned MAX_VERTICES = 64;

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_TRIANGLE = 2'd1;
  localparam logic [1:0] OP_READ     = 2'd2;

  localparam logic [63:0] DET_EPS  = 64'd43;
  localparam logic [63:0] ONE_Q32  = 64'h0000_0001_0000_0000;
  localparam logic [63:0] LIM_Q30  = 64'h0000_0000_4000_0000;
  localparam logic [63:0] LIM_Q15  = 64'd32767;
  localparam logic [6:0]  DIV_STEPS = 7'd96;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         vertex_index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic [5:0]         corner_a;
    logic [5:0]         corner_b;
    logic [5:0]         corner_c;
  } in_item_t;

  typedef struct packed {
    logic [5:0]         result_vertex;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [15:0] tangent_x;
    logic signed [15:0] tangent_y;
    logic signed [15:0] tangent_z;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] pz;
    logic signed [31:0] u;
    logic signed [31:0] v;
  } attr_t;

  typedef struct packed {
    logic signed [63:0] nx;
    logic signed [63:0] ny;
    logic signed [63:0] nz;
    logic signed [63:0] tx;
    logic signed [63:0] ty;
    logic signed [63:0] tz;
  } sum_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_T_RDA, ST_T_RDB, ST_T_RDC, ST_T_DIFF, ST_T_MUL, ST_T_DET,
    ST_T_DIVGO, ST_T_DIVWT, ST_T_SRD, ST_T_SWR, ST_R_RD, ST_R_LD, ST_PS,
    ST_SQ, ST_SQRT, ST_NDIVGO, ST_NDIVWT, ST_DOT, ST_DOTRND, ST_PROJ, ST_OUT
  } state_t;

  typedef enum logic [1:0] {VEC_NORM, VEC_TAN, VEC_RES} vec_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] v);
    mag64 = v[63] ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic signed [63:0] sign_mag(input logic [63:0] m, input logic neg);
    sign_mag = neg ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [31:0] sat_diff32(input logic signed [31:0] a,
                                                    input logic signed [31:0] b);
    logic signed [32:0] d;
    d = {a[31], a} - {b[31], b};
    if (d[32] != d[31]) sat_diff32 = d[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    else sat_diff32 = d[31:0];
  endfunction

  function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
    logic signed [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) sat_add64 = s[64] ? 64'sh8000_0000_0000_0000
                                          : 64'sh7FFF_FFFF_FFFF_FFFF;
    else sat_add64 = s[63:0];
  endfunction

  // round(v / 2^30), half away from zero
  function automatic logic signed [63:0] round_q30(input logic signed [63:0] v);
    logic [63:0] m;
    m = (mag64(v) + 64'h0000_0000_2000_0000) >> 30;
    round_q30 = sign_mag(m, v[63]);
  endfunction

endpackage

/* sv/mntg_div.sv */
// Restoring divider for the mesh normal/tangent generator, one quotient bit
// per cycle over a 96-bit dividend. Depends on mntg_pkg.
`include "mesh_normal_tangent_gen_assert.svh"
module mntg_div import mntg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [95:0] dividend,
  input  logic [63:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [63:0] quotient
);

  logic [95:0] dvd_r;
  logic [63:0] dvs_r;
  logic [63:0] rem_r;
  logic [62:0] q_r;
  logic        sat_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic        done_r;

  logic [63:0] rem_sh;
  logic        take;

  assign rem_sh = {rem_r[62:0], dvd_r[95]};
  assign take   = rem_sh >= dvs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 7'd1;
        if (cnt_r == DIV_STEPS - 7'd1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      q_r   <= '0;
      sat_r <= 1'b0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[94:0], 1'b0};
      // a set top bit before the shift means the quotient overflows
      if (q_r[62]) sat_r <= 1'b1;
      q_r   <= {q_r[61:0], take};
      rem_r <= take ? rem_sh - dvs_r : rem_sh;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = sat_r ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, q_r};

  `MNTG_ASSERT_IMP(a_div_no_restart, start, !busy_r)
  `MNTG_ASSERT_IMP(a_div_nonzero, start, divisor != 64'd0)
  `MNTG_ASSERT_IMP(a_div_done_idle, done_r, !busy_r && cnt_r == DIV_STEPS)

endmodule

/* sv/mesh_normal_tangent_gen.sv */
// Mesh per-vertex normal and tangent generator, top level.
// Depends on mntg_pkg and mntg_div.
//
// Requests enter on start/in_data and are taken when start is high and busy
// is low. A vertex write stores position and UV and clears the vertex's sums
// without raising busy. A triangle request reads its three corners, forms the
// face normal and the UV tangent on one shared 32x32 multiplier, divides the
// tangent numerator by the UV determinant in three divisions and adds both
// into the corners' saturating sums. A read request normalizes the stored
// normal, orthogonalizes and normalizes the tangent and emits one result on
// out_strobe/out_data, using nine bit-serial divisions, two bit-serial square
// roots and the one-bit-per-cycle prescale shifter. Code 3 is dropped.
// out_strobe is high for exactly one cycle per read; the receiver cannot
// stall, so the result must be captured in that cycle.
// Synchronous reset returns the sequencer to idle and marks every vertex sum
// as zero; positions and UVs stay undefined until written.
`include "mesh_normal_tangent_gen_assert.svh"
module mesh_normal_tangent_gen import mntg_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  input  in_item_t  in_data,
  output logic      busy,
  output logic      out_strobe,
  output out_item_t out_data
);

  state_t state_r, state_nxt;
  logic [4:0] cnt_r;
  vec_t vec_r;
  in_item_t req_r;

  attr_t attr_mem [MAX_VERTICES];
  sum_t  sum_mem  [MAX_VERTICES];
  logic  sval_r   [MAX_VERTICES];
  attr_t attr_q;
  sum_t  sum_q;
  logic  sval_q;
  logic [5:0] attr_raddr, sum_raddr, corner_sel;
  logic sum_we;
  sum_t sum_base, sum_new;

  attr_t pa_r, pb_r;
  logic signed [31:0] e_r [6];
  logic signed [31:0] uv_r [4];
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] prod_r, acc_r;
  logic signed [63:0] tri_r [7];
  logic signed [63:0] tan_r [3];
  logic signed [63:0] ts_r [3];
  logic [63:0] vm_r [3];
  logic        vs_r [3];
  logic [63:0] x_r, r_r, bit_r;
  logic [31:0] len_r;
  logic signed [31:0] n30_r [3];
  logic signed [31:0] d_r;
  logic signed [15:0] nout_r [3];
  logic signed [15:0] tout_r [3];
  logic out_strobe_r;
  out_item_t out_data_r;

  logic accept;
  logic [3:0] cons_idx;
  logic [1:0] ci, nd_comp;
  logic nd_f30;
  logic [63:0] mx, ps_hi, ps_lo;
  logic ps_zero, ps_down, ps_up;
  logic [63:0] sq_t, r_nxt;
  logic sq_ge;
  logic signed [63:0] tv_s [3];
  logic signed [63:0] proj_rr;
  logic [2:0] num_idx;
  logic [63:0] dq_lim;
  logic [63:0] dq_clamped;

  logic div_start, div_busy, div_done;
  logic [95:0] div_dividend;
  logic [63:0] div_divisor, div_q;

  mntg_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_q)
  );

  assign accept   = start && (state_r == ST_IDLE);
  assign cons_idx = 4'(cnt_r - 5'd1);
  assign ci       = cons_idx[1:0];
  assign num_idx  = 3'd4 + {1'b0, cnt_r[1:0]};

  always_comb begin
    for (int i = 0; i < 3; i++) tv_s[i] = sign_mag(vm_r[i], vs_r[i]);
  end

  always_comb begin
    unique case (cnt_r[1:0])
      2'd0:    corner_sel = req_r.corner_a;
      2'd1:    corner_sel = req_r.corner_b;
      default: corner_sel = req_r.corner_c;
    endcase
  end

  // prescale tests
  always_comb begin
    mx = vm_r[0];
    if (vm_r[1] > mx) mx = vm_r[1];
    if (vm_r[2] > mx) mx = vm_r[2];
    ps_hi   = (vec_r == VEC_TAN) ? 64'd1 << 24 : 64'd1 << 30;
    ps_lo   = ps_hi >> 1;
    ps_zero = mx == 64'd0;
    ps_down = !ps_zero && mx >= ps_hi;
    ps_up   = !ps_zero && mx < ps_lo;
  end

  assign sq_t  = r_r + bit_r;
  assign sq_ge = x_r >= sq_t;
  assign r_nxt = sq_ge ? (r_r >> 1) + bit_r : r_r >> 1;

  assign nd_f30  = (vec_r == VEC_NORM) && (cnt_r < 5'd3);
  assign nd_comp = (cnt_r >= 5'd3) ? 2'(cnt_r - 5'd3) : cnt_r[1:0];
  assign dq_lim  = nd_f30 ? LIM_Q30 : LIM_Q15;
  assign dq_clamped = (div_q > dq_lim) ? dq_lim : div_q;

  assign proj_rr = tv_s[ci] - round_q30(prod_r);

  assign sum_base = sval_q ? sum_q : '0;
  always_comb begin
    sum_new.nx = sat_add64(sum_base.nx, tri_r[1]);
    sum_new.ny = sat_add64(sum_base.ny, tri_r[2]);
    sum_new.nz = sat_add64(sum_base.nz, tri_r[3]);
    sum_new.tx = sat_add64(sum_base.tx, tan_r[0]);
    sum_new.ty = sat_add64(sum_base.ty, tan_r[1]);
    sum_new.tz = sat_add64(sum_base.tz, tan_r[2]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_data.operation == OP_TRIANGLE) state_nxt = ST_T_RDA;
          else if (in_data.operation == OP_READ) state_nxt = ST_R_RD;
          else state_nxt = ST_IDLE;
        end
      end
      ST_T_RDA:   state_nxt = ST_T_RDB;
      ST_T_RDB:   state_nxt = ST_T_RDC;
      ST_T_RDC:   state_nxt = ST_T_DIFF;
      ST_T_DIFF:  state_nxt = ST_T_MUL;
      ST_T_MUL:   if (cnt_r == 5'd14) state_nxt = ST_T_DET;
      ST_T_DET:   state_nxt = ST_T_DIVGO;
      ST_T_DIVGO: state_nxt = ST_T_DIVWT;
      ST_T_DIVWT: begin
        if (div_done) state_nxt = (cnt_r == 5'd2) ? ST_T_SRD : ST_T_DIVGO;
      end
      ST_T_SRD:   state_nxt = ST_T_SWR;
      ST_T_SWR:   state_nxt = (cnt_r == 5'd2) ? ST_IDLE : ST_T_SRD;
      ST_R_RD:    state_nxt = ST_R_LD;
      ST_R_LD:    state_nxt = ST_PS;
      ST_PS: begin
        if (!ps_down && !ps_up) begin
          unique case (vec_r)
            VEC_NORM: state_nxt = ps_zero ? ST_PS : ST_SQ;
            VEC_TAN:  state_nxt = ST_DOT;
            default:  state_nxt = ps_zero ? ST_OUT : ST_SQ;
          endcase
        end
      end
      ST_SQ:      if (cnt_r == 5'd3) state_nxt = ST_SQRT;
      ST_SQRT:    if (cnt_r == 5'd31) state_nxt = ST_NDIVGO;
      ST_NDIVGO:  state_nxt = ST_NDIVWT;
      ST_NDIVWT: begin
        if (div_done) begin
          priority if (vec_r == VEC_NORM && cnt_r == 5'd5) state_nxt = ST_PS;
          else if (vec_r == VEC_RES && cnt_r == 5'd2) state_nxt = ST_OUT;
          else state_nxt = ST_NDIVGO;
        end
      end
      ST_DOT:     if (cnt_r == 5'd3) state_nxt = ST_DOTRND;
      ST_DOTRND:  state_nxt = ST_PROJ;
      ST_PROJ:    if (cnt_r == 5'd3) state_nxt = ST_PS;
      ST_OUT:     state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // control outputs: memory ports, multiplier operands, divider request
  always_comb begin
    attr_raddr   = req_r.corner_a;
    sum_raddr    = corner_sel;
    sum_we       = 1'b0;
    mul_a        = '0;
    mul_b        = '0;
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = 64'd1;
    unique case (state_r)
      ST_T_RDB: attr_raddr = req_r.corner_b;
      ST_T_RDC: attr_raddr = req_r.corner_c;
      ST_T_MUL: begin
        unique case (cnt_r)
          5'd0:  begin mul_a = uv_r[0]; mul_b = uv_r[3]; end
          5'd1:  begin mul_a = uv_r[2]; mul_b = uv_r[1]; end
          5'd2:  begin mul_a = e_r[1];  mul_b = e_r[5];  end
          5'd3:  begin mul_a = e_r[2];  mul_b = e_r[4];  end
          5'd4:  begin mul_a = e_r[2];  mul_b = e_r[3];  end
          5'd5:  begin mul_a = e_r[0];  mul_b = e_r[5];  end
          5'd6:  begin mul_a = e_r[0];  mul_b = e_r[4];  end
          5'd7:  begin mul_a = e_r[1];  mul_b = e_r[3];  end
          5'd8:  begin mul_a = uv_r[3]; mul_b = e_r[0];  end
          5'd9:  begin mul_a = uv_r[1]; mul_b = e_r[3];  end
          5'd10: begin mul_a = uv_r[3]; mul_b = e_r[1];  end
          5'd11: begin mul_a = uv_r[1]; mul_b = e_r[4];  end
          5'd12: begin mul_a = uv_r[3]; mul_b = e_r[2];  end
          5'd13: begin mul_a = uv_r[1]; mul_b = e_r[5];  end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_T_DIVGO: begin
        div_start    = 1'b1;
        div_dividend = {mag64(tri_r[num_idx]), 32'd0};
        div_divisor  = mag64(tri_r[0]);
      end
      ST_T_SWR: sum_we = 1'b1;
      ST_R_RD:  sum_raddr = req_r.vertex_index;
      ST_SQ: begin
        mul_a = vm_r[cnt_r[1:0]][31:0];
        mul_b = vm_r[cnt_r[1:0]][31:0];
      end
      ST_NDIVGO: begin
        div_start    = 1'b1;
        div_dividend = 96'(nd_f30 ? vm_r[nd_comp] << 30 : vm_r[nd_comp] << 15)
                       + 96'(len_r >> 1);
        div_divisor  = 64'(len_r);
      end
      ST_DOT: begin
        mul_a = n30_r[cnt_r[1:0]];
        mul_b = tv_s[cnt_r[1:0]][31:0];
      end
      ST_PROJ: begin
        mul_a = n30_r[cnt_r[1:0]];
        mul_b = d_r;
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cnt_r        <= '0;
      out_strobe_r <= 1'b0;
      for (int i = 0; i < MAX_VERTICES; i++) sval_r[i] <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= state_r == ST_OUT;
      if (accept && in_data.operation == OP_WRITE) sval_r[in_data.vertex_index] <= 1'b0;
      if (sum_we) sval_r[corner_sel] <= 1'b1;
      unique case (state_r)
        ST_IDLE: cnt_r <= '0;
        ST_T_MUL, ST_SQ, ST_SQRT, ST_DOT, ST_PROJ:
          cnt_r <= (state_nxt == state_r) ? cnt_r + 5'd1 : '0;
        ST_T_DIVWT, ST_NDIVWT:
          if (div_done) cnt_r <= (state_nxt == ST_T_DIVGO || state_nxt == ST_NDIVGO)
                                 ? cnt_r + 5'd1 : '0;
        ST_T_SWR: cnt_r <= cnt_r + 5'd1;
        default: cnt_r <= (state_nxt == ST_T_SRD || state_nxt == ST_T_DIVGO) ? '0 : cnt_r;
      endcase
    end
  end

  // memories
  always_ff @(posedge clk) begin
    if (accept && in_data.operation == OP_WRITE) begin
      attr_mem[in_data.vertex_index] <= '{in_data.pos_x, in_data.pos_y, in_data.pos_z,
                                          in_data.tex_u, in_data.tex_v};
    end
    attr_q <= attr_mem[attr_raddr];
  end

  always_ff @(posedge clk) begin
    if (sum_we) sum_mem[corner_sel] <= sum_new;
    sum_q  <= sum_mem[sum_raddr];
    sval_q <= sval_r[sum_raddr];
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (accept) req_r <= in_data;
    unique case (state_r)
      ST_T_RDB: pa_r <= attr_q;
      ST_T_RDC: pb_r <= attr_q;
      ST_T_DIFF: begin
        e_r[0]  <= sat_diff32(pb_r.px, pa_r.px);
        e_r[1]  <= sat_diff32(pb_r.py, pa_r.py);
        e_r[2]  <= sat_diff32(pb_r.pz, pa_r.pz);
        e_r[3]  <= sat_diff32(attr_q.px, pa_r.px);
        e_r[4]  <= sat_diff32(attr_q.py, pa_r.py);
        e_r[5]  <= sat_diff32(attr_q.pz, pa_r.pz);
        uv_r[0] <= sat_diff32(pb_r.u, pa_r.u);
        uv_r[1] <= sat_diff32(pb_r.v, pa_r.v);
        uv_r[2] <= sat_diff32(attr_q.u, pa_r.u);
        uv_r[3] <= sat_diff32(attr_q.v, pa_r.v);
      end
      ST_T_MUL: begin
        // even steps load the first product, odd steps subtract the second
        if (cnt_r != 5'd0) begin
          if (!cons_idx[0]) acc_r <= prod_r;
          else tri_r[cons_idx[3:1]] <= acc_r - prod_r;
        end
      end
      ST_T_DET: if (mag64(tri_r[0]) < DET_EPS) tri_r[0] <= $signed(ONE_Q32);
      ST_T_DIVWT: begin
        if (div_done) begin
          tan_r[cnt_r[1:0]] <= sign_mag(div_q, tri_r[num_idx][63] ^ tri_r[0][63]);
        end
      end
      ST_R_LD: begin
        ts_r[0] <= sum_base.tx;
        ts_r[1] <= sum_base.ty;
        ts_r[2] <= sum_base.tz;
        vm_r[0] <= mag64(sum_base.nx); vs_r[0] <= sum_base.nx[63];
        vm_r[1] <= mag64(sum_base.ny); vs_r[1] <= sum_base.ny[63];
        vm_r[2] <= mag64(sum_base.nz); vs_r[2] <= sum_base.nz[63];
        vec_r   <= VEC_NORM;
      end
      ST_PS: begin
        priority if (ps_down) begin
          for (int i = 0; i < 3; i++) vm_r[i] <= vm_r[i] >> 1;
        end else if (ps_up) begin
          for (int i = 0; i < 3; i++) vm_r[i] <= vm_r[i] << 1;
        end else begin
          acc_r <= '0;
          if (ps_zero && vec_r == VEC_NORM) begin
            n30_r[0] <= '0; n30_r[1] <= '0; n30_r[2] <= 32'sh4000_0000;
            nout_r[0] <= '0; nout_r[1] <= '0; nout_r[2] <= 16'sd32767;
            for (int i = 0; i < 3; i++) begin
              vm_r[i] <= mag64(ts_r[i]);
              vs_r[i] <= ts_r[i][63];
            end
            vec_r <= VEC_TAN;
          end
          if (ps_zero && vec_r == VEC_RES) begin
            tout_r[0] <= 16'sd32767; tout_r[1] <= '0; tout_r[2] <= '0;
          end
        end
      end
      ST_SQ: begin
        if (cnt_r != 5'd0) acc_r <= acc_r + prod_r;
        if (cnt_r == 5'd3) begin
          x_r   <= acc_r + prod_r;
          r_r   <= '0;
          bit_r <= 64'd1 << 62;
        end
      end
      ST_SQRT: begin
        if (sq_ge) x_r <= x_r - sq_t;
        r_r   <= r_nxt;
        bit_r <= bit_r >> 2;
        if (cnt_r == 5'd31) len_r <= r_nxt[31:0];
      end
      ST_NDIVWT: begin
        if (div_done) begin
          priority if (nd_f30) n30_r[nd_comp] <= 32'(sign_mag(dq_clamped, vs_r[nd_comp]));
          else if (vec_r == VEC_NORM)
            nout_r[nd_comp] <= 16'(sign_mag(dq_clamped, vs_r[nd_comp]));
          else tout_r[nd_comp] <= 16'(sign_mag(dq_clamped, vs_r[nd_comp]));
          if (vec_r == VEC_NORM && cnt_r == 5'd5) begin
            for (int i = 0; i < 3; i++) begin
              vm_r[i] <= mag64(ts_r[i]);
              vs_r[i] <= ts_r[i][63];
            end
            vec_r <= VEC_TAN;
          end
        end
      end
      ST_DOT: if (cnt_r != 5'd0) acc_r <= acc_r + prod_r;
      ST_DOTRND: d_r <= 32'(round_q30(acc_r));
      ST_PROJ: begin
        if (cnt_r != 5'd0) begin
          vm_r[ci] <= mag64(proj_rr);
          vs_r[ci] <= proj_rr[63];
        end
        if (cnt_r == 5'd3) vec_r <= VEC_RES;
      end
      ST_OUT: begin
        out_data_r.result_vertex <= req_r.vertex_index;
        out_data_r.normal_x  <= nout_r[0];
        out_data_r.normal_y  <= nout_r[1];
        out_data_r.normal_z  <= nout_r[2];
        out_data_r.tangent_x <= tout_r[0];
        out_data_r.tangent_y <= tout_r[1];
        out_data_r.tangent_z <= tout_r[2];
      end
      default: ;
    endcase
  end

  assign busy       = state_r != ST_IDLE;
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

  `MNTG_ASSERT_NXT(a_strobe_single, out_strobe, !out_strobe)
  `MNTG_ASSERT_IMP(a_strobe_idle, out_strobe, !busy)
  `MNTG_ASSERT_NXT(a_read_busy, start && !busy && in_data.operation == OP_READ, busy)
  `MNTG_ASSERT_IMP(a_div_quiet, state_r == ST_IDLE, !div_busy)

endmodule
